// ----- src/rid_pkg.sv -----
// ----------------------------------------------------------------------------
// rid_pkg
// shared widths, constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package rid_pkg;

  localparam int CH_W     = 8;              // one colour channel
  localparam int SQ_W     = 2 * CH_W;       // one squared difference
  localparam int ADD_W    = SQ_W + 2;       // sum of three squares
  localparam int SUM_W    = 34;             // running square sum
  localparam int FRAC_W   = 8;              // fraction bits of the distance
  localparam int RAD_W    = SUM_W + 2 * FRAC_W;  // radicand width
  localparam int DIST_W   = RAD_W / 2;      // root width, 25 bits
  localparam int SQ_STEPS = DIST_W;         // one root bit per step
  localparam int CNT_W    = $clog2(SQ_STEPS);
  localparam int REM_W    = DIST_W + 1;     // partial remainder
  localparam int TRIAL_W  = REM_W + 2;

  // commands from controller to datapath
  typedef struct packed {
    logic start;     // take the final sum as radicand, clear the sum
    logic step;      // one root iteration
    logic load_out;  // copy the root into the output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic pipe_last;  // the pipeline stage holds the final pair of an image
  } sts_t;

endpackage

// ----- src/rid_datapath.sv -----
// ----------------------------------------------------------------------------
// rid_datapath
// squared channel differences, saturating accumulator and bit-serial root
// ----------------------------------------------------------------------------
module rid_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_accept,
  input  logic [rid_pkg::CH_W-1:0]   first_red,
  input  logic [rid_pkg::CH_W-1:0]   first_green,
  input  logic [rid_pkg::CH_W-1:0]   first_blue,
  input  logic [rid_pkg::CH_W-1:0]   second_red,
  input  logic [rid_pkg::CH_W-1:0]   second_green,
  input  logic [rid_pkg::CH_W-1:0]   second_blue,
  input  logic                       last_pixel,
  input  rid_pkg::cmd_t              cmd,
  output rid_pkg::sts_t              sts,
  output logic [rid_pkg::DIST_W-1:0] distance
);

  logic [rid_pkg::CH_W-1:0]    diff_r, diff_g, diff_b;
  logic [rid_pkg::SQ_W-1:0]    sq_r, sq_g, sq_b;
  logic [rid_pkg::ADD_W-1:0]   add_next;

  logic                        pipe_valid;
  logic                        pipe_last;
  logic [rid_pkg::ADD_W-1:0]   pipe_add;

  logic [rid_pkg::SUM_W-1:0]   square_sum;
  logic [rid_pkg::SUM_W:0]     sum_wide;
  logic [rid_pkg::SUM_W-1:0]   sum_sat;

  logic [rid_pkg::SUM_W-1:0]   radicand;
  logic [rid_pkg::REM_W-1:0]   rem;
  logic [rid_pkg::DIST_W-1:0]  root;
  logic [rid_pkg::TRIAL_W-1:0] rem_sh, trial, rem_diff;

  // absolute differences and squares
  always_comb begin
    diff_r = (first_red   >= second_red)   ? first_red - second_red
                                           : second_red - first_red;
    diff_g = (first_green >= second_green) ? first_green - second_green
                                           : second_green - first_green;
    diff_b = (first_blue  >= second_blue)  ? first_blue - second_blue
                                           : second_blue - first_blue;
    sq_r     = diff_r * diff_r;
    sq_g     = diff_g * diff_g;
    sq_b     = diff_b * diff_b;
    add_next = rid_pkg::ADD_W'(sq_r) + rid_pkg::ADD_W'(sq_g) + rid_pkg::ADD_W'(sq_b);
  end

  // saturating accumulate
  always_comb begin
    sum_wide = {1'b0, square_sum} + (rid_pkg::SUM_W + 1)'(pipe_add);
    sum_sat  = sum_wide[rid_pkg::SUM_W] ? {rid_pkg::SUM_W{1'b1}}
                                        : sum_wide[rid_pkg::SUM_W-1:0];
  end

  // one restoring root step: two radicand bits in, one root bit out
  always_comb begin
    rem_sh   = {rem, radicand[rid_pkg::SUM_W-1 -: 2]};
    trial    = {1'b0, root, 2'b01};
    rem_diff = rem_sh - trial;
  end

  assign sts.pipe_last = pipe_valid & pipe_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
      square_sum <= '0;
    end else begin
      pipe_valid <= in_accept;
      if (cmd.start) begin
        square_sum <= '0;
      end else if (pipe_valid) begin
        square_sum <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pipe_last <= last_pixel;
      pipe_add  <= add_next;
    end
    if (cmd.start) begin
      radicand <= sum_sat;
      rem      <= '0;
      root     <= '0;
    end else if (cmd.step) begin
      radicand <= {radicand[rid_pkg::SUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_diff[rid_pkg::REM_W-1:0];
        root <= {root[rid_pkg::DIST_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[rid_pkg::REM_W-1:0];
        root <= {root[rid_pkg::DIST_W-2:0], 1'b0};
      end
    end
    if (cmd.load_out) begin
      distance <= root;
    end
  end

endmodule

// ----- src/rid_controller.sv -----
// ----------------------------------------------------------------------------
// rid_controller
// sequences the root iterations and owns both handshakes
// ----------------------------------------------------------------------------
module rid_controller (
  input  logic          clk,
  input  logic          rst,
  input  rid_pkg::sts_t sts,
  input  logic          out_stall,
  output rid_pkg::cmd_t cmd,
  output logic          in_stall,
  output logic          out_valid
);

  typedef enum logic [1:0] {
    IDLE,
    ROOT,
    DONE
  } state_t;

  state_t                    state;
  logic [rid_pkg::CNT_W-1:0] cnt;

  always_comb begin
    cmd.start    = (state == IDLE) && sts.pipe_last;
    cmd.step     = (state == ROOT);
    cmd.load_out = (state == DONE) && (!out_valid || !out_stall);
    in_stall     = (state != IDLE) || sts.pipe_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (sts.pipe_last) begin
            state <= ROOT;
            cnt   <= rid_pkg::CNT_W'(rid_pkg::SQ_STEPS - 1);
          end
        end
        ROOT: begin
          if (cnt == '0) begin
            state <= DONE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        DONE: begin
          if (!out_valid || !out_stall) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase

      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/rgb_image_euclidean_distance.sv -----
// throughput: one pixel pair per cycle within an image; after its final pair
//   the input is held (pipeline register, 25 root bits at one a cycle, one load),
//   longer while an earlier result beat is still stalled
// output register: the next image streams in while a result beat waits
// reset: synchronous, clears the square sum, pipeline and output valid
// ----------------------------------------------------------------------------
// rgb_image_euclidean_distance
// euclidean distance between two rgb images, streamed one pixel pair a beat
// ----------------------------------------------------------------------------
module rgb_image_euclidean_distance (
  input  logic                       clk,
  input  logic                       rst,
  // pixel pair channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [rid_pkg::CH_W-1:0]   first_red,
  input  logic [rid_pkg::CH_W-1:0]   first_green,
  input  logic [rid_pkg::CH_W-1:0]   first_blue,
  input  logic [rid_pkg::CH_W-1:0]   second_red,
  input  logic [rid_pkg::CH_W-1:0]   second_green,
  input  logic [rid_pkg::CH_W-1:0]   second_blue,
  input  logic                       last_pixel,
  // distance channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rid_pkg::DIST_W-1:0] distance
);

  // command and status between controller and datapath
  rid_pkg::cmd_t cmd;
  rid_pkg::sts_t sts;
  logic          in_accept;

  // a beat is taken when valid and not stalled
  assign in_accept = in_valid && !in_stall;

  // datapath: squares go through one register stage, then into the 34-bit
  // saturating sum; the final pair's sum feeds the bit-serial root
  rid_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .in_accept    (in_accept),
    .first_red    (first_red),
    .first_green  (first_green),
    .first_blue   (first_blue),
    .second_red   (second_red),
    .second_green (second_green),
    .second_blue  (second_blue),
    .last_pixel   (last_pixel),
    .cmd          (cmd),
    .sts          (sts),
    .distance     (distance)
  );

  // controller: input held from the final pair until the root is parked in
  // the output register
  rid_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .sts       (sts),
    .out_stall (out_stall),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // no beat is taken behind a final pair before its root starts
  a_hold_after_last: assert property (@(posedge clk) disable iff (rst)
    sts.pipe_last |-> in_stall)
    else $error("pixel beat taken behind a final pair");

  // root iteration follows the radicand load directly
  a_step_after_start: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> cmd.step)
    else $error("root iteration did not start after load");

  // a result beat only appears from an output register load
  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("distance beat without a root result");

  // loading never overwrites a result beat that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("distance overwritten while stalled");

endmodule

// ----- tb/sv/image_distance_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// image_distance_checker
// watches both channels of the distance block, keeps its own running square
// sum, works out each image's floored fixed point distance and compares every
// distance beat with the oldest distance still due
// ----------------------------------------------------------------------------
module image_distance_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [rid_pkg::CH_W-1:0]   first_red,
  input  logic [rid_pkg::CH_W-1:0]   first_green,
  input  logic [rid_pkg::CH_W-1:0]   first_blue,
  input  logic [rid_pkg::CH_W-1:0]   second_red,
  input  logic [rid_pkg::CH_W-1:0]   second_green,
  input  logic [rid_pkg::CH_W-1:0]   second_blue,
  input  logic                       last_pixel,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [rid_pkg::DIST_W-1:0] distance,
  output int                         errors,
  output int                         awaited
);

  localparam logic [rid_pkg::SUM_W:0] SUM_CEILING = {1'b0, {rid_pkg::SUM_W{1'b1}}};

  logic [rid_pkg::SUM_W-1:0]  square_acc = '0;
  logic [rid_pkg::DIST_W-1:0] distance_due[$];

  function automatic logic [rid_pkg::SQ_W-1:0] channel_gap_sq(
    input logic [rid_pkg::CH_W-1:0] a,
    input logic [rid_pkg::CH_W-1:0] b
  );
    logic [rid_pkg::CH_W-1:0] d;
    d = (a >= b) ? a - b : b - a;
    return rid_pkg::SQ_W'(d) * rid_pkg::SQ_W'(d);
  endfunction

  // floor(sqrt(acc * 2^16)), one root bit at a time from the top
  function automatic logic [rid_pkg::DIST_W-1:0] fixed_point_root(
    input logic [rid_pkg::SUM_W-1:0] acc
  );
    logic [63:0]                rad;
    logic [63:0]                sq;
    logic [rid_pkg::DIST_W-1:0] root;
    logic [rid_pkg::DIST_W-1:0] trial;
    rad  = 64'(acc) << (2 * rid_pkg::FRAC_W);
    root = '0;
    for (int b = rid_pkg::DIST_W - 1; b >= 0; b--) begin
      trial = root | (rid_pkg::DIST_W'(1) << b);
      sq    = 64'(trial) * 64'(trial);
      if (sq <= rad) root = trial;
    end
    return root;
  endfunction

  always @(posedge clk) begin
    logic [rid_pkg::SUM_W:0]    total;
    logic [rid_pkg::DIST_W-1:0] want;
    if (rst) begin
      errors <= 0;
    end else begin
      // pixel pair beat: fold into the sum, saturating
      if (in_valid && !in_stall) begin
        total = {1'b0, square_acc}
              + (rid_pkg::SUM_W + 1)'(channel_gap_sq(first_red, second_red))
              + (rid_pkg::SUM_W + 1)'(channel_gap_sq(first_green, second_green))
              + (rid_pkg::SUM_W + 1)'(channel_gap_sq(first_blue, second_blue));
        if (total > SUM_CEILING) total = SUM_CEILING;
        if (last_pixel) begin
          distance_due.push_back(fixed_point_root(total[rid_pkg::SUM_W-1:0]));
          square_acc = '0;
        end else begin
          square_acc = total[rid_pkg::SUM_W-1:0];
        end
      end
      // distance beat
      if (out_valid && !out_stall) begin
        if (distance_due.size() == 0) begin
          $error("distance beat with nothing due: actual %0d", distance);
          errors <= errors + 1;
        end else begin
          want = distance_due.pop_front();
          if (distance !== want) begin
            $error("distance mismatch: expected %0d, actual %0d", want, distance);
            errors <= errors + 1;
          end
        end
      end
    end
    awaited <= distance_due.size();
  end

endmodule

// ----- tb/sv/tb_rgb_image_euclidean_distance.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_image_euclidean_distance
// streams images of pixel pairs into the distance block and checks each
// image's distance through a side checker; covers channel extremes, single
// pixel images and random images under random gaps on both channels
// ----------------------------------------------------------------------------
module tb_rgb_image_euclidean_distance;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;  // far beyond the slowest pass
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RANDOM_PAIRS = 1750;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // pixel pair channel
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic [rid_pkg::CH_W-1:0]   first_red    = '0;
  logic [rid_pkg::CH_W-1:0]   first_green  = '0;
  logic [rid_pkg::CH_W-1:0]   first_blue   = '0;
  logic [rid_pkg::CH_W-1:0]   second_red   = '0;
  logic [rid_pkg::CH_W-1:0]   second_green = '0;
  logic [rid_pkg::CH_W-1:0]   second_blue  = '0;
  logic                       last_pixel   = 1'b0;
  // distance channel
  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic [rid_pkg::DIST_W-1:0] distance;

  int          errors;
  int          awaited;
  int unsigned cycle_count = 0;
  int unsigned pairs_sent  = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_draw;
  bit          steady      = 1'b0;  // both sides run without gaps while set

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgb_image_euclidean_distance dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .first_red    (first_red),
    .first_green  (first_green),
    .first_blue   (first_blue),
    .second_red   (second_red),
    .second_green (second_green),
    .second_blue  (second_blue),
    .last_pixel   (last_pixel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .distance     (distance)
  );

  image_distance_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .first_red    (first_red),
    .first_green  (first_green),
    .first_blue   (first_blue),
    .second_red   (second_red),
    .second_green (second_green),
    .second_blue  (second_blue),
    .last_pixel   (last_pixel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .distance     (distance),
    .errors       (errors),
    .awaited      (awaited)
  );

  // watchdog, also catches a distance that never turns up
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // distance side: after each taken beat draw whether and how long to hold stall,
  // and now and then raise it while nothing is offered so it also meets a fresh result
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end else if (out_valid && !out_stall) begin
      stall_draw = steady ? 0 : $urandom_range(0, 7);
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end else if (!steady && !out_valid && $urandom_range(0, 31) == 0) begin
      stall_draw = $urandom_range(1, 7);
      stall_left <= stall_draw;
      out_stall  <= 1'b1;
    end
  end

  // one pixel pair beat; valid stays high straight into the next beat when
  // no gap is drawn, so it is never lowered and raised in one step
  task automatic send_pair(
    input logic [rid_pkg::CH_W-1:0] fr,
    input logic [rid_pkg::CH_W-1:0] fg,
    input logic [rid_pkg::CH_W-1:0] fb,
    input logic [rid_pkg::CH_W-1:0] sr,
    input logic [rid_pkg::CH_W-1:0] sg,
    input logic [rid_pkg::CH_W-1:0] sb,
    input logic                     lastp
  );
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    first_red    <= fr;
    first_green  <= fg;
    first_blue   <= fb;
    second_red   <= sr;
    second_green <= sg;
    second_blue  <= sb;
    last_pixel   <= lastp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pairs_sent++;
  endtask

  // channel values lean towards the extremes
  function automatic logic [rid_pkg::CH_W-1:0] pick_channel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    else if (r == 1) return '1;
    else return rid_pkg::CH_W'($urandom);
  endfunction

  // mostly short images so plenty of distances come back, a few long ones
  function automatic int unsigned pick_image_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 8);
    else if (r < 97) return $urandom_range(9, 40);
    else return $urandom_range(41, 300);
  endfunction

  task automatic send_random_image(input int unsigned len);
    logic [rid_pkg::CH_W-1:0] fr, fg, fb, sr, sg, sb;
    for (int unsigned k = 0; k < len; k++) begin
      fr = pick_channel();
      fg = pick_channel();
      fb = pick_channel();
      if ($urandom_range(0, 9) == 0) begin
        // identical pixels add nothing
        sr = fr;
        sg = fg;
        sb = fb;
      end else begin
        sr = pick_channel();
        sg = pick_channel();
        sb = pick_channel();
      end
      send_pair(fr, fg, fb, sr, sg, sb, k == len - 1);
    end
  endtask

  initial begin
    int unsigned goal;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: single pixel images at the extremes
    send_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);  // zero distance
    send_pair(8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 1'b1);  // largest one-pixel sum
    send_pair(8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 1'b1);  // second image larger
    send_pair(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1);  // equal at top
    send_pair(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);  // smallest non-zero
    send_pair(8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 1'b1);  // alternating bits
    send_pair(8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 1'b1);
    // one channel at a time across a three pixel image
    send_pair(8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_pair(8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_pair(8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 1'b1);
    // mixed four pixel image, then an image whose sum stays zero
    send_pair(8'h80, 8'h7f, 8'h01, 8'h7f, 8'h80, 8'hfe, 1'b0);
    send_pair(8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60, 1'b0);
    send_pair(8'hfe, 8'h01, 8'hc3, 8'h3c, 8'hfe, 8'h01, 1'b0);
    send_pair(8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 1'b1);
    send_pair(8'h12, 8'h34, 8'h56, 8'h12, 8'h34, 8'h56, 1'b0);
    send_pair(8'h9a, 8'hbc, 8'hde, 8'h9a, 8'hbc, 8'hde, 1'b1);

    // random images, some stretches with no idling on either side
    goal = pairs_sent + RANDOM_PAIRS;
    while (pairs_sent < goal) begin
      steady = ($urandom_range(0, 7) == 0);
      send_random_image(pick_image_len());
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // wait for every distance, then a little longer for strays
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
src/rid_pkg.sv
src/rid_datapath.sv
src/rid_controller.sv
src/rgb_image_euclidean_distance.sv
tb/sv/image_distance_checker.sv
tb/sv/tb_rgb_image_euclidean_distance.sv
